// ===== design/bcd_clock_card_registers_core_macros.svh =====
// ----------------------------------------------------------------------------
// Clock card register core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_CARD_REGISTERS_CORE_MACROS_SVH
`define BCD_CLOCK_CARD_REGISTERS_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define BCCR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("clock card register check failed");

// The consequent holds in the same cycle as the antecedent.
`define BCCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clock card register check failed");

// The consequent holds in the cycle after the antecedent.
`define BCCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clock card register check failed");

`endif

// ===== design/bccr_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock card register package
// Register indexes, mode codes, string templates and BCD helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bccr_pkg;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [3:0] REG_SECOND   = 4'd7;
	localparam logic [3:0] REG_MODE     = 4'd8;
	localparam logic [3:0] REG_LENGTH   = 4'd9;
	localparam logic [3:0] REG_POSITION = 4'd10;
	localparam logic [3:0] REG_CHAR     = 4'd11;

	localparam logic [7:0] MODE_SHORT   = 8'hA3;
	localparam logic [7:0] MODE_LONG_A  = 8'hBE;
	localparam logic [7:0] MODE_LONG_B  = 8'hA0;
	localparam logic [7:0] MODE_LONG_C  = 8'hA5;
	localparam logic [7:0] MODE_DATED   = 8'hA4;

	localparam logic [4:0] LEN_NONE  = 5'd0;
	localparam logic [4:0] LEN_SHORT = 5'd14;
	localparam logic [4:0] LEN_LONG  = 5'd21;
	localparam logic [4:0] LEN_DATED = 5'd17;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HIGH  = 8'h80;
	localparam logic [7:0] CH_DIGIT = 8'hB0;

	// Template codes below this value name a BCD nibble: pair in bits 3:1,
	// high nibble when bit 0 is clear.
	localparam logic [7:0] CODE_LITERAL = 8'd16;

	typedef enum logic [1:0] {
		FMT_SHORT,
		FMT_LONG,
		FMT_DATED
	} fmt_t;

	function automatic logic [4:0] mode_length(input logic [7:0] m);
		logic [4:0] len;
		case (m) inside
			MODE_SHORT: len = LEN_SHORT;
			MODE_LONG_A, MODE_LONG_B, MODE_LONG_C: len = LEN_LONG;
			MODE_DATED: len = LEN_DATED;
			default: len = LEN_NONE;
		endcase
		return len;
	endfunction

	function automatic fmt_t length_fmt(input logic [4:0] len);
		fmt_t f;
		case (len)
			LEN_SHORT: f = FMT_SHORT;
			LEN_LONG:  f = FMT_LONG;
			default:   f = FMT_DATED;
		endcase
		return f;
	endfunction

	// Two BCD digits of a value below 256; the tens digit is taken mod 10.
	function automatic logic [7:0] bcd_pair(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  tens;
		logic [7:0]  ones;
		logic [4:0]  tens_m;
		prod = {8'd0, v} * 16'd205;
		tens = prod[15:11];
		ones = v - ({3'd0, tens} * 8'd10);
		if (tens >= 5'd20) begin
			tens_m = tens - 5'd20;
		end else if (tens >= 5'd10) begin
			tens_m = tens - 5'd10;
		end else begin
			tens_m = tens;
		end
		return {tens_m[3:0], ones[3:0]};
	endfunction

	function automatic logic [7:0] tpl_code(input fmt_t f, input logic [4:0] idx);
		logic [7:0] c;
		c = CH_SPACE;
		case (f)
			FMT_SHORT: begin
				case (idx)
					5'd0: c = 8'd4;
					5'd1: c = 8'd5;
					5'd3: c = 8'd8;
					5'd4: c = 8'd9;
					5'd6: c = 8'd6;
					5'd7: c = 8'd7;
					5'd9: c = 8'd10;
					5'd10: c = 8'd11;
					5'd12: c = 8'd12;
					5'd13: c = 8'd13;
					default: c = CH_COMMA;
				endcase
			end
			FMT_LONG: begin
				case (idx)
					5'd0, 5'd6, 5'd7: c = CH_SPACE;
					5'd1: c = 8'd4;
					5'd2: c = 8'd5;
					5'd3: c = CH_SLASH;
					5'd4: c = 8'd6;
					5'd5: c = 8'd7;
					5'd8: c = 8'd10;
					5'd9: c = 8'd11;
					5'd10, 5'd13, 5'd16: c = CH_SEMI;
					5'd11: c = 8'd12;
					5'd12: c = 8'd13;
					5'd14: c = 8'd14;
					5'd15: c = 8'd15;
					5'd17: c = CH_DOT;
					default: c = CH_ZERO;
				endcase
			end
			default: begin
				case (idx)
					5'd0: c = 8'd0;
					5'd1: c = 8'd1;
					5'd2, 5'd5: c = CH_SLASH;
					5'd3: c = 8'd4;
					5'd4: c = 8'd5;
					5'd6: c = 8'd6;
					5'd7: c = 8'd7;
					5'd8: c = CH_SPACE;
					5'd9: c = 8'd10;
					5'd10: c = 8'd11;
					5'd11, 5'd14: c = CH_SEMI;
					5'd12: c = 8'd12;
					5'd13: c = 8'd13;
					5'd15: c = 8'd14;
					default: c = 8'd15;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/bcd_clock_card_registers_core.sv =====
// ----------------------------------------------------------------------------
// Clock card register core
// Sixteen byte register window returning BCD time, mode and string bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bcd_clock_card_registers_core_macros.svh"

// Each bus request carries a binary time and one register access. Reads of
// registers 0 to 7 return the BCD year low pair, year high pair, month, day,
// weekday, hour, minute and second; 8 returns the mode, 9 the string length,
// 10 the character position and 11 the character of the selected time
// string at that position, with bit 7 set, or 0 when no mode is set or the
// position is past the string end; 12 to 15 read 0. A read produces exactly
// one response; a write produces none. The core takes one request per cycle
// while in_stall is low. The request is captured in an input register, where
// the year is also split into hundreds and remainder, and a read response is
// built in a single pass into the output register. While the output register
// holds an unaccepted response, the next request still enters the input
// register; a read in the input register waits only when the output register
// is full and stalled. Writes update the mode, length and position registers
// as they leave the input register, so every read sees all earlier writes.
module bcd_clock_card_registers_core
	import bccr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [3:0]  address,
	input  wire logic [7:0]  write_data,
	input  wire logic [13:0] year,
	input  wire logic [3:0]  month,
	input  wire logic [4:0]  day,
	input  wire logic [2:0]  weekday,
	input  wire logic [4:0]  hour,
	input  wire logic [5:0]  minute,
	input  wire logic [5:0]  second,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data
);

	// Input register stage.
	logic        valid_s1;
	logic        kind_s1;
	logic [3:0]  address_s1;
	logic [7:0]  data_s1;
	logic [7:0]  year_hi_s1;
	logic [6:0]  year_lo_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [2:0]  weekday_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;

	// Architectural state and output register.
	logic [7:0]  mode_q;
	logic [4:0]  string_length_q;
	logic [7:0]  char_position_q;
	logic        out_valid_q;
	logic [7:0]  read_data_q;

	logic        accept;
	logic        go_s1;
	logic        load_out;
	logic        do_write;

	// Year split at capture: the reciprocal of 100 is exact below 43699.
	logic [26:0] year_prod;
	logic [7:0]  year_hi_w;
	logic [13:0] year_rem_w;

	logic [7:0]  bcd_w [8];
	logic [4:0]  cur_len_w;
	logic [4:0]  new_len_w;
	logic [7:0]  code_w;
	logic [7:0]  pair_w;
	logic [3:0]  nib_w;
	logic [7:0]  char_w;
	logic [7:0]  result_w;

	assign accept   = in_valid && !in_stall;
	assign go_s1    = valid_s1 && (kind_s1 == KIND_WRITE || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go_s1;
	assign load_out = go_s1 && kind_s1 == KIND_READ;
	assign do_write = go_s1 && kind_s1 == KIND_WRITE;

	assign year_prod  = {13'd0, year} * 27'd5243;
	assign year_hi_w  = year_prod[26:19];
	assign year_rem_w = year - 14'({6'd0, year_hi_w} * 14'd100);

	always_comb begin
		bcd_w[0] = bcd_pair({1'b0, year_lo_s1});
		bcd_w[1] = bcd_pair(year_hi_s1);
		bcd_w[2] = bcd_pair({4'd0, month_s1});
		bcd_w[3] = bcd_pair({3'd0, day_s1});
		bcd_w[4] = bcd_pair({5'd0, weekday_s1});
		bcd_w[5] = bcd_pair({3'd0, hour_s1});
		bcd_w[6] = bcd_pair({2'd0, minute_s1});
		bcd_w[7] = bcd_pair({2'd0, second_s1});
	end

	// String character at the current position; 0 when the mode is unset or
	// the position has fallen past the end after a switch to a shorter mode.
	always_comb begin
		cur_len_w = mode_length(mode_q);
		code_w    = tpl_code(length_fmt(cur_len_w), char_position_q[4:0]);
		pair_w    = bcd_w[code_w[3:1]];
		nib_w     = code_w[0] ? pair_w[3:0] : pair_w[7:4];
		if (cur_len_w == LEN_NONE) begin
			char_w = 8'd0;
		end else if (char_position_q >= {3'd0, cur_len_w}
				|| char_position_q >= {3'd0, string_length_q}) begin
			char_w = 8'd0;
		end else if (code_w < CODE_LITERAL) begin
			char_w = CH_DIGIT + {4'd0, nib_w};
		end else begin
			char_w = code_w | CH_HIGH;
		end
	end

	always_comb begin
		case (address_s1) inside
			[4'd0:REG_SECOND]: result_w = bcd_w[address_s1[2:0]];
			REG_MODE:          result_w = mode_q;
			REG_LENGTH:        result_w = {3'd0, string_length_q};
			REG_POSITION:      result_w = char_position_q;
			REG_CHAR:          result_w = char_w;
			default:           result_w = 8'd0;
		endcase
	end

	// Length after a mode write: an unknown code keeps the current mode.
	assign new_len_w = mode_length(data_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			mode_q          <= 8'd0;
			string_length_q <= 5'd0;
			char_position_q <= 8'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end

			if (do_write && address_s1 == REG_MODE && new_len_w != LEN_NONE) begin
				mode_q          <= data_s1;
				string_length_q <= new_len_w;
			end
			if (do_write && address_s1 == REG_POSITION
					&& data_s1 < {3'd0, string_length_q}) begin
				char_position_q <= data_s1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind;
			address_s1 <= address;
			data_s1    <= write_data;
			year_hi_s1 <= year_hi_w;
			year_lo_s1 <= year_rem_w[6:0];
			month_s1   <= month;
			day_s1     <= day;
			weekday_s1 <= weekday;
			hour_s1    <= hour;
			minute_s1  <= minute;
			second_s1  <= second;
		end
		if (load_out) begin
			read_data_q <= result_w;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	`BCCR_ASSERT_ALWAYS(a_len_tracks_mode, string_length_q == mode_length(mode_q))
	`BCCR_ASSERT_ALWAYS(a_mode_known, mode_q == 8'd0 || mode_length(mode_q) != LEN_NONE)
	`BCCR_ASSERT_IMP(a_stall_needs_item, !valid_s1, !in_stall)
	`BCCR_ASSERT_NEXT(a_write_no_result, do_write, out_valid_q == $past(out_valid_q && out_stall))

endmodule

`default_nettype wire
